>>> rtl/clist_pkg.sv
// Shared types for the compacting indexed list core: operation and status
// codes and the sequencer state encoding. No dependencies.
package clist_pkg;

   // Operation codes carried in the request
   typedef enum logic [2:0] {
      OP_APPEND      = 3'd0,
      OP_REMOVE_LAST = 3'd1,
      OP_ERASE       = 3'd2,
      OP_READ_INDEX  = 3'd3,
      OP_READ_FIRST  = 3'd4,
      OP_READ_LAST   = 3'd5,
      OP_CLEAR       = 3'd6
   } op_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_BAD_INDEX = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // Sequencer states, one-hot
   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_MOVE_RD = 5'b00010,
      S_MOVE_WR = 5'b00100,
      S_RESP    = 5'b01000,
      S_SPARE   = 5'b10000
   } state_type;

   // Stream field widths and total stream widths
   localparam int unsigned OP_W     = 3;
   localparam int unsigned POS_W    = 4;
   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned RDVAL_W  = 32;
   localparam int unsigned COUNT_W  = 5;
   localparam int unsigned REQ_W    = 40;
   localparam int unsigned RSP_W    = 40;

endpackage

>>> rtl/compacting_indexed_list_core.sv
// Compacting indexed list core: ordered list held in one on-chip memory,
// worked by a small sequencer with a single read and a single write port.
// Depends on clist_pkg (operation, status and state types).
//
// The core keeps up to DEPTH elements of ELEMENT_WIDTH bits in insertion
// order. Each request transfer carries one operation (append, remove last,
// erase at index, read at index, read first, read last, clear) and yields
// exactly one response transfer with status, read data and element count
// after the operation. Timing: a request is taken only while the sequencer
// is idle. Every operation takes the sequencer through accept, then
// hand-off to the response register; an erase that moves entries adds a
// read state and a write state per entry moved, since each moved
// entry needs one memory read followed by one memory write through the
// shared single-port pair. A finished response waits in its output
// register, so the next request may be accepted while it is still pending;
// the sequencer holds only if a second result is ready before the first
// is taken. The memory needs no clearing pass: only entries below the
// count are ever read, and each of those was written by an append or a move.
module compacting_indexed_list_core #(
   parameter int unsigned DEPTH         = 16,
   parameter int unsigned ELEMENT_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   // Request stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [2:0] operation, [6:3] position, [38:7] value, [39] zero
   input  logic [clist_pkg::REQ_W-1:0]      req_tdata,
   // Response stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [1:0] status, [33:2] read_value, [38:34] count, [39] zero
   output logic [clist_pkg::RSP_W-1:0]      rsp_tdata
);

   localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW   = $clog2(DEPTH + 1);
   localparam int unsigned CMPW = (CW > clist_pkg::POS_W) ? CW : clist_pkg::POS_W;
   localparam int unsigned EW   = ELEMENT_WIDTH;

   // Element storage
   logic [EW-1:0] mem_ff [DEPTH];
   logic [EW-1:0] rd_data_ff;

   // Sequencer and list state
   clist_pkg::state_type  state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [AW-1:0]         ptr_ff, ptr_in;
   clist_pkg::status_type status_ff, status_in;
   logic                  rd_sel_ff, rd_sel_in;

   // Response register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [clist_pkg::RSP_W-1:0]   rsp_data_ff, rsp_data_in;

   // Memory port controls
   logic          mem_re;
   logic [AW-1:0] mem_raddr;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [EW-1:0] mem_wdata;

   // Request fields
   logic                          accept;
   clist_pkg::op_type             req_op;
   logic [clist_pkg::POS_W-1:0]   req_pos;
   logic [clist_pkg::VALUE_W-1:0] req_value;
   logic [CMPW-1:0]               pos_ext;
   logic [AW-1:0]                 pos_addr;
   logic                          bad_pos;
   logic                          list_empty;
   logic                          list_full;
   logic [63:0]                   value_wide;
   logic [63:0]                   rd_wide;
   logic [AW-1:0]                 ptr_inc;
   logic [CW-1:0]                 count_dec;
   logic                          slot_free;
   logic [clist_pkg::COUNT_W-1:0] count_out;

   assign req_tready = (state_ff == clist_pkg::S_IDLE);
   assign accept     = req_tvalid && req_tready;

   assign req_op    = clist_pkg::op_type'(req_tdata[2:0]);
   assign req_pos   = req_tdata[6:3];
   assign req_value = req_tdata[38:7];

   assign pos_ext    = CMPW'(req_pos);
   assign pos_addr   = pos_ext[AW-1:0];
   assign bad_pos    = pos_ext >= CMPW'(count_ff);
   assign list_empty = (count_ff == '0);
   assign list_full  = (count_ff == CW'(DEPTH));
   assign count_dec  = count_ff - CW'(1);
   assign count_out  = clist_pkg::COUNT_W'(count_ff);

   // Zero-extend or truncate between the 32-bit stream fields and elements
   assign value_wide = 64'(req_value);
   assign rd_wide    = 64'(rd_data_ff);

   assign ptr_inc   = ptr_ff + AW'(1);
   assign slot_free = !rsp_valid_ff || rsp_tready;

   // Sequencer: decode on accept, walk erase compaction, hand off result
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      ptr_in    = ptr_ff;
      status_in = status_ff;
      rd_sel_in = rd_sel_ff;
      mem_re    = 1'b0;
      mem_raddr = ptr_inc;
      mem_we    = 1'b0;
      mem_waddr = ptr_ff;
      mem_wdata = rd_data_ff;

      unique case (state_ff)
         clist_pkg::S_IDLE: begin
            if (accept) begin
               status_in = clist_pkg::ST_OK;
               rd_sel_in = 1'b0;
               state_in  = clist_pkg::S_RESP;
               case (req_op)
                  clist_pkg::OP_APPEND: begin
                     if (list_full) begin
                        status_in = clist_pkg::ST_FULL;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = count_ff[AW-1:0];
                        mem_wdata = value_wide[EW-1:0];
                        count_in  = count_ff + CW'(1);
                     end
                  end
                  clist_pkg::OP_REMOVE_LAST: begin
                     if (list_empty) begin
                        status_in = clist_pkg::ST_EMPTY;
                     end else begin
                        count_in = count_dec;
                     end
                  end
                  clist_pkg::OP_ERASE: begin
                     if (bad_pos) begin
                        status_in = clist_pkg::ST_BAD_INDEX;
                     end else begin
                        // count drops now; compaction runs up to the new count
                        count_in = count_dec;
                        ptr_in   = pos_addr;
                        if (CMPW'(count_dec) > pos_ext) begin
                           state_in = clist_pkg::S_MOVE_RD;
                        end
                     end
                  end
                  clist_pkg::OP_READ_INDEX: begin
                     if (bad_pos) begin
                        status_in = clist_pkg::ST_BAD_INDEX;
                     end else begin
                        mem_re    = 1'b1;
                        mem_raddr = pos_addr;
                        rd_sel_in = 1'b1;
                     end
                  end
                  clist_pkg::OP_READ_FIRST: begin
                     if (list_empty) begin
                        status_in = clist_pkg::ST_EMPTY;
                     end else begin
                        mem_re    = 1'b1;
                        mem_raddr = '0;
                        rd_sel_in = 1'b1;
                     end
                  end
                  clist_pkg::OP_READ_LAST: begin
                     if (list_empty) begin
                        status_in = clist_pkg::ST_EMPTY;
                     end else begin
                        mem_re    = 1'b1;
                        mem_raddr = count_dec[AW-1:0];
                        rd_sel_in = 1'b1;
                     end
                  end
                  clist_pkg::OP_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     // unused code: no change, status ok
                  end
               endcase
            end
         end
         clist_pkg::S_MOVE_RD: begin
            // fetch the entry above the hole
            mem_re    = 1'b1;
            mem_raddr = ptr_inc;
            state_in  = clist_pkg::S_MOVE_WR;
         end
         clist_pkg::S_MOVE_WR: begin
            // drop it one place down and advance while a source entry is left
            mem_we    = 1'b1;
            mem_waddr = ptr_ff;
            mem_wdata = rd_data_ff;
            ptr_in    = ptr_inc;
            if (CW'(ptr_inc) < count_ff) begin
               state_in = clist_pkg::S_MOVE_RD;
            end else begin
               state_in = clist_pkg::S_RESP;
            end
         end
         clist_pkg::S_RESP: begin
            if (slot_free) begin
               state_in = clist_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = clist_pkg::S_IDLE;
         end
      endcase
   end

   // Output register: load on hand-off, clear when the transfer completes
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == clist_pkg::S_RESP) && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0,
                         count_out,
                         rd_sel_ff ? rd_wide[clist_pkg::RDVAL_W-1:0]
                                   : {clist_pkg::RDVAL_W{1'b0}},
                         status_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Element memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem_ff[mem_raddr];
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= clist_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload state
   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      status_ff   <= status_in;
      rd_sel_ff   <= rd_sel_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
